>>> src/coap_pkg.sv
package coap_pkg;

  localparam int unsigned MaxToken = 8;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_TOKEN,
    PH_OPT,
    PH_DEXT1,
    PH_DEXT2,
    PH_LEXT1,
    PH_LEXT2,
    PH_VALUE,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    K_HDR     = 3'd0,
    K_HDRDONE = 3'd1,
    K_TOKEN   = 3'd2,
    K_OPTION  = 3'd3,
    K_VALUE   = 3'd4,
    K_PAYLOAD = 3'd5,
    K_MARKER  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic [1:0]  msg_type;
    logic [7:0]  code;
    logic [15:0] msg_id;
    logic [3:0]  token_len;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic        frame_end;
    logic        malformed;
  } out_item_t;

  // Classified byte passed from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_marker;
    logic [3:0] hi_nib;
    logic [3:0] lo_nib;
  } class_t;

endpackage

>>> src/coap_if.sv
interface coap_in_if import coap_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface coap_out_if import coap_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/coap_front.sv
module coap_front import coap_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  coap_in_if.sink        in_ch,
  output logic           q_valid,
  input  logic           q_ready,
  output class_t         q_data
);

  // Two-entry queue of classified bytes.
  class_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  class_t     cls;

  // Classify the incoming byte.
  always_comb begin
    cls.data_byte = in_ch.data.data_byte;
    cls.last_byte = in_ch.data.last_byte;
    cls.is_marker = (in_ch.data.data_byte == 8'hff);
    cls.hi_nib    = in_ch.data.data_byte[7:4];
    cls.lo_nib    = in_ch.data.data_byte[3:0];
  end

  assign in_ch.ready = (count != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
`endif

endmodule

>>> src/coap_back.sv
module coap_back import coap_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  output logic     q_ready,
  input  class_t   q_data,
  coap_out_if.source out_ch
);

  phase_t      phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [3:0]  token_left, token_left_next;
  logic [15:0] previous_number, previous_number_next;
  logic [3:0]  delta_nib, delta_nib_next;
  logic [3:0]  length_nibble, length_nibble_next;
  logic [7:0]  ext_high, ext_high_next;
  logic [15:0] delta_value, delta_value_next;
  logic [15:0] value_left, value_left_next;
  logic        error_seen, error_seen_next;
  logic [1:0]  held_type, held_type_next;
  logic [7:0]  held_code, held_code_next;
  logic [15:0] held_id, held_id_next;
  logic [3:0]  held_token_len, held_token_len_next;
  logic [15:0] held_opt_len, held_opt_len_next;

  logic        out_valid;
  out_item_t   out_reg;
  out_item_t   res;
  logic        emit;
  logic        take;
  logic [2:0]  kind;
  logic [7:0]  echo;
  logic        err;
  logic        done;
  logic        bad;
  logic        st_opt;
  logic [15:0] st_len;
  logic        aft_delta;
  logic [7:0]  b;
  logic        last;

  // Output register stays loadable while the consumer takes the old request.
  assign q_ready      = !out_valid || out_ch.ready;
  assign take         = q_valid && q_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_reg;
  assign b            = q_data.data_byte;
  assign last         = q_data.last_byte;

  // Parser next-state logic.
  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    token_left_next      = token_left;
    previous_number_next = previous_number;
    delta_nib_next       = delta_nib;
    length_nibble_next   = length_nibble;
    ext_high_next        = ext_high;
    delta_value_next     = delta_value;
    value_left_next      = value_left;
    error_seen_next      = error_seen;
    held_type_next       = held_type;
    held_code_next       = held_code;
    held_id_next         = held_id;
    held_token_len_next  = held_token_len;
    held_opt_len_next    = held_opt_len;
    kind      = K_HDR;
    echo      = 8'd0;
    err       = 1'b0;
    done      = 1'b0;
    st_opt    = 1'b0;
    st_len    = 16'd0;
    aft_delta = 1'b0;

    unique case (phase)
      PH_HDR: begin
        unique case (header_index)
          2'd0: begin
            held_type_next       = q_data.hi_nib[1:0];
            held_token_len_next  = q_data.lo_nib;
            held_code_next       = 8'd0;
            held_id_next         = 16'd0;
            previous_number_next = 16'd0;
            held_opt_len_next    = 16'd0;
            value_left_next      = 16'd0;
            if (b[7:6] != 2'd1 || q_data.lo_nib > 4'(MaxToken)) err = 1'b1;
            header_index_next = 2'd1;
          end
          2'd1: begin
            held_code_next = b;
            if (b == 8'd0 && held_token_len != 4'd0) err = 1'b1;
            header_index_next = 2'd2;
          end
          2'd2: begin
            held_id_next      = {b, 8'd0};
            header_index_next = 2'd3;
          end
          default: begin
            held_id_next      = {held_id[15:8], b};
            header_index_next = 2'd0;
            kind              = K_HDRDONE;
            token_left_next   = held_token_len;
            if (held_token_len != 4'd0) begin
              phase_next = PH_TOKEN;
            end else begin
              phase_next = PH_OPT;
              done       = 1'b1;
            end
          end
        endcase
      end
      PH_TOKEN: begin
        kind            = K_TOKEN;
        echo            = b;
        token_left_next = token_left - 4'd1;
        if (token_left == 4'd1) begin
          phase_next = PH_OPT;
          done       = 1'b1;
        end
      end
      PH_OPT: begin
        if (q_data.is_marker) begin
          kind       = K_MARKER;
          phase_next = PH_PAYLOAD;
        end else begin
          delta_nib_next     = q_data.hi_nib;
          length_nibble_next = q_data.lo_nib;
          if (q_data.hi_nib == 4'd15 || q_data.lo_nib == 4'd15) begin
            err = 1'b1;
          end else if (q_data.hi_nib >= 4'd13) begin
            phase_next = PH_DEXT1;
          end else begin
            delta_value_next = {12'd0, q_data.hi_nib};
            aft_delta        = 1'b1;
          end
        end
      end
      PH_DEXT1: begin
        if (delta_nib == 4'd13) begin
          delta_value_next = 16'd13 + {8'd0, b};
          aft_delta        = 1'b1;
        end else begin
          ext_high_next = b;
          phase_next    = PH_DEXT2;
        end
      end
      PH_DEXT2: begin
        delta_value_next = 16'd269 + {ext_high, b};
        aft_delta        = 1'b1;
      end
      PH_LEXT1: begin
        if (length_nibble == 4'd13) begin
          st_opt = 1'b1;
          st_len = 16'd13 + {8'd0, b};
        end else begin
          ext_high_next = b;
          phase_next    = PH_LEXT2;
        end
      end
      PH_LEXT2: begin
        st_opt = 1'b1;
        st_len = 16'd269 + {ext_high, b};
      end
      PH_VALUE: begin
        kind            = K_VALUE;
        echo            = b;
        value_left_next = value_left - 16'd1;
        if (value_left == 16'd1) begin
          phase_next = PH_OPT;
          done       = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        kind = K_PAYLOAD;
        echo = b;
        done = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // Delta complete: either fetch an extended length or start the option.
    if (aft_delta) begin
      if (length_nibble_next >= 4'd13) begin
        phase_next = PH_LEXT1;
      end else begin
        st_opt = 1'b1;
        st_len = {12'd0, length_nibble_next};
      end
    end

    if (st_opt) begin
      previous_number_next = previous_number + delta_value_next;
      held_opt_len_next    = st_len;
      value_left_next      = st_len;
      kind                 = K_OPTION;
      if (st_len != 16'd0) begin
        phase_next = PH_VALUE;
      end else begin
        phase_next = PH_OPT;
        done       = 1'b1;
      end
    end

    emit = 1'b1;
    bad  = 1'b0;
    if (err && !last) begin
      phase_next      = PH_DROP;
      error_seen_next = 1'b1;
      emit            = 1'b0;
    end
    if (last) begin
      if (err || !done || error_seen) begin
        bad  = 1'b1;
        kind = K_HDR;
        echo = 8'd0;
      end
      phase_next        = PH_HDR;
      header_index_next = 2'd0;
      error_seen_next   = 1'b0;
    end

    res.kind          = kind;
    res.byte_out      = echo;
    res.msg_type      = held_type_next;
    res.code          = held_code_next;
    res.msg_id        = held_id_next;
    res.token_len     = held_token_len_next;
    res.option_number = previous_number_next;
    res.option_length = held_opt_len_next;
    res.frame_end     = last;
    res.malformed     = bad;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      header_index    <= 2'd0;
      token_left      <= 4'd0;
      previous_number <= 16'd0;
      delta_nib       <= 4'd0;
      length_nibble   <= 4'd0;
      ext_high        <= 8'd0;
      delta_value     <= 16'd0;
      value_left      <= 16'd0;
      error_seen      <= 1'b0;
      held_type       <= 2'd0;
      held_code       <= 8'd0;
      held_id         <= 16'd0;
      held_token_len  <= 4'd0;
      held_opt_len    <= 16'd0;
    end else if (take) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      token_left      <= token_left_next;
      previous_number <= previous_number_next;
      delta_nib       <= delta_nib_next;
      length_nibble   <= length_nibble_next;
      ext_high        <= ext_high_next;
      delta_value     <= delta_value_next;
      value_left      <= value_left_next;
      error_seen      <= error_seen_next;
      held_type       <= held_type_next;
      held_code       <= held_code_next;
      held_id         <= held_id_next;
      held_token_len  <= held_token_len_next;
      held_opt_len    <= held_opt_len_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_reg <= res;
    end
  end

`ifndef SYNTHESIS
  a_err_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_reg.malformed || out_reg.frame_end))
    else $error("error flag without frame end");
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_DROP && !last) |=> !out_valid)
    else $error("dropped byte produced a result");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> (phase == PH_HDR && header_index == 2'd0))
    else $error("frame end did not return to header");
`endif

endmodule

>>> src/coap_message_parser_top.sv
// CoAP message parser, RFC 7252 framing.
// Input channel in_ch carries one message byte per request with a flag
// on the frame's last byte. Output channel out_ch carries one tagged
// result per byte: kind, echoed byte, held header fields, the current
// option number and length, and at frame end an ok or error flag.
// Bytes that follow a protocol error inside a frame give no result, and
// a malformed frame ends with a single error result on its last byte.
// A front stage classifies bytes into a two-entry queue; the back stage
// runs the parser state machine and loads an output register.
// A result is registered: an accepted byte passes the queue and then the
// output register. The parser takes one byte per cycle unless the
// receiver stalls.
// Synchronous reset returns the parser to expect a first header byte
// and empties the queue and the output register.
// When the receiver stalls, the output register holds its result, the
// parser stops, the queue fills, and in_ch.ready drops once the queue
// holds two bytes; no byte is lost.
module coap_message_parser_top import coap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  coap_in_if.sink     in_ch,
  coap_out_if.source  out_ch
);

  logic   q_valid;
  logic   q_ready;
  class_t q_data;

  coap_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  coap_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule
